/* hdl/fmpc_pkg.sv */
// Package for the first-match packet classifier: opcodes, status codes and
// the rule record. No dependencies.
package fmpc_pkg;

  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_POS  = 2'd2;

  localparam logic [1:0] RP_TCP      = 2'd1;
  localparam logic [1:0] RP_UDP      = 2'd2;

  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam int         ADDR_BITS   = 32;

  typedef struct packed {
    logic [1:0]  direction;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [15:0] s_port;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [15:0] d_port;
    logic [1:0]  protocol;
    logic        verdict;
  } rule_t;

  // Select of the leading bits that a mask asks to compare. The count of
  // leading ones gives the length; a zero mask compares all bits.
  function automatic logic [31:0] prefix_sel(input logic [31:0] mask);
    logic [31:0] sel;
    logic        run;
    sel = '0;
    run = 1'b1;
    if (mask == '0) begin
      sel = '1;
    end else begin
      for (int i = ADDR_BITS - 1; i >= 0; i--) begin
        run = run & mask[i];
        sel[i] = run;
      end
    end
    return sel;
  endfunction

endpackage

/* hdl/fmpc_if.sv */
// Valid/ready channel interfaces of the classifier.
// Depends on nothing.
interface fmpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  direction;
  logic [31:0] src_addr;
  logic [31:0] src_mask;
  logic [15:0] src_port_num;
  logic [31:0] dst_addr;
  logic [31:0] dst_mask;
  logic [15:0] dst_port_num;
  logic [7:0]  ip_protocol;
  logic [1:0]  rule_protocol;
  logic        rule_verdict;
  logic [6:0]  rule_position;
  modport source (output valid, opcode, direction, src_addr, src_mask, src_port_num,
                  dst_addr, dst_mask, dst_port_num, ip_protocol, rule_protocol,
                  rule_verdict, rule_position, input ready);
  modport sink (input valid, opcode, direction, src_addr, src_mask, src_port_num,
                dst_addr, dst_mask, dst_port_num, ip_protocol, rule_protocol,
                rule_verdict, rule_position, output ready);
endinterface

interface fmpc_out_if;
  logic       valid;
  logic       ready;
  logic       drop;
  logic       matched;
  logic [6:0] match_position;
  logic [1:0] status;
  logic [6:0] rules_held;
  modport source (output valid, drop, matched, match_position, status, rules_held,
                  input ready);
  modport sink (input valid, drop, matched, match_position, status, rules_held,
                output ready);
endinterface

/* hdl/first_match_packet_classifier.sv */
// Channel  | Dir | Payload
// in       | in  | opcode, packet or rule fields, delete position
// out      | out | drop, matched, match_position, status, rules_held
//
// Append writes the rule as it is taken. Classify reads the rules in order up
// to the first match (all N rules held when none matches). Delete at position
// p moves each later rule down one place: one rule table read per cycle on the
// single read port.
// Reset clears the rule count; table contents need no clearing.
// A waiting result holds the block; the next item is taken once it leaves.
// Depends on fmpc_pkg and fmpc_if.
module first_match_packet_classifier
  import fmpc_pkg::*;
#(
  parameter int MAX_RULES = 64
) (
  input logic clk,
  input logic rst,
  fmpc_in_if.sink    in,
  fmpc_out_if.source out
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  rule_t  mem [MAX_RULES];
  rule_t  rd_data;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;       // index of the entry whose data arrives this cycle in a scan; a shift gets idx+1
  logic          rd_pend;   // the entry read last cycle is a held rule

  // Packet held during a scan.
  logic [1:0]  p_dir;
  logic [31:0] p_sa, p_da;
  logic [15:0] p_sp, p_dp;
  logic [7:0]  p_proto;

  logic        hit;
  logic        proto_ok;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  rule_t       wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    proto_ok = 1'b1;
    if (rd_data.protocol == RP_TCP && p_proto != PROTO_TCP) proto_ok = 1'b0;
    if (rd_data.protocol == RP_UDP && p_proto != PROTO_UDP) proto_ok = 1'b0;
    hit = (rd_data.direction == p_dir) && proto_ok
        && (rd_data.src_addr == '0
            || ((p_sa ^ rd_data.src_addr) & prefix_sel(rd_data.src_mask)) == '0)
        && (rd_data.dst_addr == '0
            || ((p_da ^ rd_data.dst_addr) & prefix_sel(rd_data.dst_mask)) == '0)
        && (rd_data.s_port == '0 || rd_data.s_port == p_sp)
        && (rd_data.d_port == '0 || rd_data.d_port == p_dp);
  end

  logic acc;
  assign acc = in.valid && in.ready;
  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_DONE);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    rd_addr = '0;
    if (state == S_IDLE && acc && in.opcode == OP_APPEND && count < CW'(MAX_RULES)) begin
      wr_en = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = '{in.direction, in.src_addr, in.src_mask, in.src_port_num,
                  in.dst_addr, in.dst_mask, in.dst_port_num, in.rule_protocol,
                  in.rule_verdict};
    end
    if (state == S_IDLE) begin
      if (in.opcode == OP_DELETE) rd_addr = AW'(in.rule_position);
    end else if (state == S_SCAN) begin
      rd_addr = AW'(idx + CW'(1));
    end else if (state == S_SHIFT) begin
      rd_addr = AW'(idx + CW'(2));
      // Entry idx+1 arrived; move it down one place.
      wr_en = rd_pend;
      wr_addr = idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx <= '0;
      rd_pend <= 1'b0;
      out.drop <= 1'b0;
      out.matched <= 1'b0;
      out.match_position <= '0;
      out.status <= ST_OK;
      out.rules_held <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            out.drop <= 1'b0;
            out.matched <= 1'b0;
            out.match_position <= '0;
            out.status <= ST_OK;
            p_dir <= in.direction;
            p_sa <= in.src_addr;
            p_da <= in.dst_addr;
            p_proto <= in.ip_protocol;
            if (in.ip_protocol == PROTO_TCP || in.ip_protocol == PROTO_UDP) begin
              p_sp <= in.src_port_num;
              p_dp <= in.dst_port_num;
            end else begin
              p_sp <= '0;
              p_dp <= '0;
            end
            idx <= '0;
            rd_pend <= 1'b0;
            state <= S_DONE;
            out.rules_held <= 7'(count);
            case (in.opcode)
              OP_CLASSIFY: begin
                if (count != '0) begin
                  state <= S_SCAN;
                  rd_pend <= 1'b1;
                end
              end
              OP_APPEND: begin
                if (count < CW'(MAX_RULES)) begin
                  count <= count + CW'(1);
                  out.rules_held <= 7'(count + CW'(1));
                end else begin
                  out.status <= ST_FULL;
                end
              end
              OP_DELETE: begin
                if (in.rule_position == '0 || 32'(in.rule_position) > 32'(count)) begin
                  out.status <= ST_BAD_POS;
                end else begin
                  idx <= CW'(in.rule_position - 7'd1);
                  rd_pend <= (32'(in.rule_position) < 32'(count));
                  state <= S_SHIFT;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            out.matched <= 1'b1;
            out.drop <= ~rd_data.verdict;
            out.match_position <= 7'(idx + CW'(1));
            state <= S_DONE;
          end else if (idx + CW'(1) >= count) begin
            state <= S_DONE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SHIFT: begin
          if (!rd_pend || idx + CW'(2) >= count) begin
            count <= count - CW'(1);
            out.rules_held <= 7'(count - CW'(1));
            state <= S_DONE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          if (out.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/fmpc_checker.sv */
// Port-level checks of the classifier, bound to the top level.
// Depends on fmpc_pkg and the top level's ports.
module fmpc_checker
  import fmpc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drop,
  input logic       matched,
  input logic [6:0] match_position,
  input logic [1:0] status
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_position))
    else $error("result changed while stalled");
  a_match_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (matched == (match_position != 7'd0)))
    else $error("matched and position disagree");
  a_drop_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && drop |-> matched && status == ST_OK)
    else $error("drop without a match");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");
endmodule

bind first_match_packet_classifier fmpc_checker u_fmpc_checker (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .drop(out.drop),
  .matched(out.matched), .match_position(out.match_position), .status(out.status)
);

/* tb/fmpc_scoreboard.sv */
// Scoreboard for the first-match packet classifier: a rule table predictor
// and a queue of expected results. Depends on fmpc_pkg.
package fmpc_tb_pkg;
  import fmpc_pkg::*;

  typedef struct {
    logic [1:0]  opcode;
    logic [1:0]  direction;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [15:0] s_port;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [15:0] d_port;
    logic [7:0]  ip_protocol;
    logic [1:0]  rule_protocol;
    logic        rule_verdict;
    logic [6:0]  rule_position;
  } request_t;

  typedef struct {
    logic       drop;
    logic       matched;
    logic [6:0] match_position;
    logic [1:0] status;
    logic [6:0] rules_held;
  } verdict_t;

  class classifier_scoreboard;
    rule_t    rules[$];
    verdict_t pending[$];
    int       error_count;

    function void note_request(request_t r);
      verdict_t v;
      rule_t    nr;
      logic [15:0] sp, dp;
      v = '{default: '0};
      if (r.opcode == OP_CLASSIFY) begin
        sp = r.s_port;
        dp = r.d_port;
        if (r.ip_protocol != PROTO_TCP && r.ip_protocol != PROTO_UDP) begin
          sp = '0;
          dp = '0;
        end
        foreach (rules[k]) begin
          if (rule_hits(rules[k], r, sp, dp)) begin
            v.matched = 1'b1;
            v.match_position = 7'(k + 1);
            v.drop = !rules[k].verdict;
            break;
          end
        end
      end else if (r.opcode == OP_APPEND) begin
        if (rules.size() >= 64) begin
          v.status = ST_FULL;
        end else begin
          nr = '{r.direction, r.src_addr, r.src_mask, r.s_port, r.dst_addr,
                 r.dst_mask, r.d_port, r.rule_protocol, r.rule_verdict};
          rules.push_back(nr);
        end
      end else if (r.opcode == OP_DELETE) begin
        if (r.rule_position == 0 || r.rule_position > rules.size()) begin
          v.status = ST_BAD_POS;
        end else begin
          rules.delete(r.rule_position - 1);
        end
      end
      v.rules_held = 7'(rules.size());
      pending.push_back(v);
    endfunction

    static function bit prefix_hit(logic [31:0] pkt, logic [31:0] addr, logic [31:0] mask);
      int len;
      logic [31:0] sel;
      len = 32;
      if (mask != 0) begin
        len = 0;
        while (len < 32 && mask[31 - len]) len++;
      end
      if (len == 0) return 1;
      sel = 32'hFFFF_FFFF << (32 - len);
      return ((pkt ^ addr) & sel) == 0;
    endfunction

    static function bit rule_hits(rule_t q, request_t r, logic [15:0] sp, logic [15:0] dp);
      if (q.direction != r.direction) return 0;
      if (q.protocol == RP_TCP && r.ip_protocol != PROTO_TCP) return 0;
      if (q.protocol == RP_UDP && r.ip_protocol != PROTO_UDP) return 0;
      if (q.src_addr != 0 && !prefix_hit(r.src_addr, q.src_addr, q.src_mask)) return 0;
      if (q.dst_addr != 0 && !prefix_hit(r.dst_addr, q.dst_addr, q.dst_mask)) return 0;
      if (q.s_port != 0 && q.s_port != sp) return 0;
      if (q.d_port != 0 && q.d_port != dp) return 0;
      return 1;
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
    endtask

    task check_verdict(verdict_t got);
      verdict_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = pending.pop_front();
        if (got.drop !== w.drop) report("drop", got.drop, w.drop);
        if (got.matched !== w.matched) report("matched", got.matched, w.matched);
        if (got.match_position !== w.match_position)
          report("match_position", got.match_position, w.match_position);
        if (got.status !== w.status) report("status", got.status, w.status);
        if (got.rules_held !== w.rules_held)
          report("rules_held", got.rules_held, w.rules_held);
      end
    endtask
  endclass
endpackage

/* tb/tb_top.sv */
// Top-level testbench of first_match_packet_classifier: directed and random
// rule table traffic checked by the scoreboard. Depends on fmpc_pkg, fmpc_if
// and fmpc_scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fmpc_pkg::*;
  import fmpc_tb_pkg::*;

  logic clk;
  logic rst;
  fmpc_in_if  in_ch();
  fmpc_out_if out_ch();
  classifier_scoreboard board;
  bit calm;          // no idling on either side
  bit hold_sink;     // long receiver hold-off
  bit sending_done;

  first_match_packet_classifier u_dut (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Address pool so that random packets often hit stored rules.
  logic [31:0] addr_pool[4] = '{32'h0A00_0001, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'h8000_0000};
  logic [15:0] port_pool[3] = '{16'd80, 16'd443, 16'hFFFF};

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 0;
      default: return addr_pool[$urandom_range(0, 3)] ^ ($urandom_range(0, 1) ? $urandom_range(0, 255) : 0);
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return 32'hFFFF_FFFF << $urandom_range(0, 32);
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'($urandom());
      default: return port_pool[$urandom_range(0, 2)];
    endcase
  endfunction

  function automatic request_t random_request(logic [1:0] op);
    request_t r;
    r.opcode = op;
    r.direction = $urandom_range(0, 9) == 0 ? 2'($urandom()) : 2'($urandom_range(1, 2));
    r.src_addr = pick_addr();
    r.src_mask = pick_mask();
    r.s_port = pick_port();
    r.dst_addr = pick_addr();
    r.dst_mask = pick_mask();
    r.d_port = pick_port();
    case ($urandom_range(0, 3))
      0: r.ip_protocol = 8'($urandom());
      1: r.ip_protocol = PROTO_UDP;
      default: r.ip_protocol = PROTO_TCP;
    endcase
    r.rule_protocol = 2'($urandom());
    r.rule_verdict = 1'($urandom());
    r.rule_position = $urandom_range(0, 9) == 0 ? 7'($urandom()) :
                      7'($urandom_range(0, board.rules.size() + 1));
    return r;
  endfunction

  task automatic send(request_t r);
    while (!calm && $urandom_range(0, 99) < 14) @(negedge clk);
    in_ch.valid <= 1;
    in_ch.opcode <= r.opcode;
    in_ch.direction <= r.direction;
    in_ch.src_addr <= r.src_addr;
    in_ch.src_mask <= r.src_mask;
    in_ch.src_port_num <= r.s_port;
    in_ch.dst_addr <= r.dst_addr;
    in_ch.dst_mask <= r.dst_mask;
    in_ch.dst_port_num <= r.d_port;
    in_ch.ip_protocol <= r.ip_protocol;
    in_ch.rule_protocol <= r.rule_protocol;
    in_ch.rule_verdict <= r.rule_verdict;
    in_ch.rule_position <= r.rule_position;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(r);
    @(negedge clk);
    // A following item may raise valid again at this same edge.
    in_ch.valid = 0;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: random idling, plus a long hold-off on request.
  initial begin
    verdict_t v;
    out_ch.ready = 0;
    @(negedge clk);
    forever begin
      out_ch.ready <= !hold_sink && (calm || $urandom_range(0, 99) >= 14);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        v.drop = out_ch.drop;
        v.matched = out_ch.matched;
        v.match_position = out_ch.match_position;
        v.status = out_ch.status;
        v.rules_held = out_ch.rules_held;
        board.check_verdict(v);
      end
      @(negedge clk);
    end
  end

  initial begin
    request_t r;
    board = new();
    in_ch.valid = 0;
    in_ch.opcode = OP_CLASSIFY;
    in_ch.direction = 0;
    in_ch.src_addr = 0;
    in_ch.src_mask = 0;
    in_ch.src_port_num = 0;
    in_ch.dst_addr = 0;
    in_ch.dst_mask = 0;
    in_ch.dst_port_num = 0;
    in_ch.ip_protocol = 0;
    in_ch.rule_protocol = 0;
    in_ch.rule_verdict = 0;
    in_ch.rule_position = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty table, bad deletes, unused opcode, field extremes.
    r = random_request(OP_CLASSIFY);
    send(r);
    r.opcode = OP_DELETE; r.rule_position = 0; send(r);
    r.rule_position = 7'h7F; send(r);
    r.opcode = OP_NONE; send(r);
    // Rule with all-ones fields and one with all zero wildcards.
    r = '{OP_APPEND, 2'd3, '1, '1, '1, '1, '1, '1, '1, 2'd3, 1'b0, '1};
    send(r);
    r.opcode = OP_CLASSIFY; send(r);
    r.ip_protocol = 8'd0; send(r);
    r = '{OP_APPEND, 2'd0, '0, '0, '0, '0, '0, '0, '0, 2'd0, 1'b1, '0};
    send(r);
    r.opcode = OP_CLASSIFY; send(r);
    r.direction = 2'd1; send(r);
    // Mask without a leading one matches any address.
    r = '{OP_APPEND, 2'd1, 32'h0A00_0001, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, RP_TCP,
          1'b0, '0};
    send(r);
    r.opcode = OP_CLASSIFY; r.src_addr = 32'h5555_5555; r.ip_protocol = PROTO_TCP; send(r);
    r.ip_protocol = PROTO_UDP; send(r);
    r.opcode = OP_DELETE; r.rule_position = 1; send(r);
    r.rule_position = 2; send(r);
    r.opcode = OP_CLASSIFY; r.ip_protocol = PROTO_TCP; send(r);

    // Fill to the limit and try one more append.
    calm = 1;
    while (board.rules.size() < 64) send(random_request(OP_APPEND));
    send(random_request(OP_APPEND));
    r = random_request(OP_DELETE); r.rule_position = 64; send(r);
    r.rule_position = 1; send(r);
    calm = 0;

    // Long receiver hold-off while items keep arriving.
    fork
      begin
        hold_sink = 1;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      repeat (5) send(random_request(OP_CLASSIFY));
    join

    for (int i = 0; i < 600; i++) begin
      int pick;
      if (i == 300) wait_drained();
      calm = (i >= 400 && i < 460);
      pick = $urandom_range(0, 99);
      if (pick < 55) r = random_request(OP_CLASSIFY);
      else if (pick < 80 || board.rules.size() < 4) r = random_request(OP_APPEND);
      else if (pick < 97) r = random_request(OP_DELETE);
      else r = random_request(OP_NONE);
      send(r);
    end
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    wait_drained();
    repeat (150) @(negedge clk);
    if (board.error_count == 0)
      $display("first_match_packet_classifier verification clean");
    else
      $display("first_match_packet_classifier verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("first_match_packet_classifier verification failed");
    $finish;
  end
endmodule
